// ===== rtl/dfst_pkg.sv =====
// shared types, constants and latencies of the diagonal fold scale transform
package dfst_pkg;

  // internal coordinate, signed q.20 held in 64 bits
  typedef logic signed [63:0] coord_t;
  typedef logic [2:0] reg_index_t;

  // register indexes of the configuration port
  localparam reg_index_t REG_OFFSET  = 3'd0;
  localparam reg_index_t REG_SCALE   = 3'd1;
  localparam reg_index_t REG_ROT_EN  = 3'd2;
  localparam reg_index_t REG_ROW0    = 3'd3;
  localparam reg_index_t REG_ROW1    = 3'd4;
  localparam reg_index_t REG_ROW2    = 3'd5;

  // register reset values
  localparam logic [59:0] OFFSET_RST = {20'h10000, 20'h10000, 20'h10000};
  localparam logic [59:0] SCALE_RST  = {20'h40000, 20'h40000, 20'h40000};
  localparam logic [53:0] ROW0_RST   = {18'h00000, 18'h00000, 18'h10000};
  localparam logic [53:0] ROW1_RST   = {18'h00000, 18'h10000, 18'h00000};
  localparam logic [53:0] ROW2_RST   = {18'h10000, 18'h00000, 18'h00000};

  // basis constants in q.24
  localparam logic signed [24:0] K_S23 = 25'sd13698540;
  localparam logic signed [24:0] K_S13 = 25'sd9686330;
  localparam logic signed [24:0] K_S12 = 25'sd11863283;
  localparam int K_SHIFT  = 24;
  localparam int SC_SHIFT = 16;

  localparam logic [47:0] ONE_DE = 48'd65536;
  localparam logic [47:0] DE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam coord_t INNER_LIM = (64'sd1 <<< 58) - 64'sd1;

  // unit latencies in cycles
  localparam int MUL_LAT     = 2;
  localparam int SQRT_STAGES = 16;
  localparam int LEN_LAT     = 6 + SQRT_STAGES;
  localparam int DIV_STAGES  = 24;
  localparam int MD_LAT      = 4 + DIV_STAGES;

  // symmetric clamp of an intermediate value
  function automatic coord_t clamp_inner(input coord_t v);
    if (v > INNER_LIM) begin
      return INNER_LIM;
    end else if (v < -INNER_LIM) begin
      return -INNER_LIM;
    end else begin
      return v;
    end
  endfunction

endpackage

// ===== rtl/dfst_pipe.sv =====
// enabled delay line for aligning side data with the pipeline
module dfst_pipe #(
  parameter int W = 64,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] st [DEPTH];

  // shift on each advance
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        st[i] <= st[i-1];
      end
    end
  end

  assign q = st[DEPTH-1];

endmodule

// ===== rtl/dfst_mulr.sv =====
// two stage signed multiply by a coefficient with round half away from zero
module dfst_mulr #(
  parameter int CW = 25,
  parameter int SHIFT = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  dfst_pkg::coord_t     v,
  input  logic signed [CW-1:0] c,
  output dfst_pkg::coord_t     r
);
  import dfst_pkg::*;

  localparam int PW = 64 + CW;
  localparam int RW = PW - SHIFT;
  localparam logic [RW-1:0] LIM = {{(RW-63){1'b0}}, 1'b1, 62'b0};

  logic [63:0]    m;
  logic [CW-1:0]  cm;
  logic [31+CW:0] pl;
  logic [31+CW:0] ph;
  logic           neg;
  logic [PW-1:0]  prod;
  logic [RW-1:0]  rr;
  logic [RW-1:0]  rs;

  // magnitudes
  always_comb begin
    m  = v[63] ? 64'(-v) : 64'(v);
    cm = c[CW-1] ? CW'(-c) : CW'(c);
  end

  // partial products on the low and high halves
  always_ff @(posedge clk) begin
    if (en) begin
      pl  <= m[31:0] * cm;
      ph  <= m[63:32] * cm;
      neg <= v[63] ^ c[CW-1];
    end
  end

  // combine, round and limit
  always_comb begin
    prod = {ph, 32'b0} + PW'(pl);
    rr   = RW'((prod + (PW'(1) << (SHIFT - 1))) >> SHIFT);
    rs   = (rr > LIM) ? LIM : rr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= neg ? -coord_t'(rs[63:0]) : coord_t'(rs[63:0]);
    end
  end

endmodule

// ===== rtl/dfst_len3.sv =====
// pipelined euclidean length of three components with range normalization
module dfst_len3 (
  input  logic             clk,
  input  logic             en,
  input  dfst_pkg::coord_t a,
  input  dfst_pkg::coord_t b,
  input  dfst_pkg::coord_t c,
  output dfst_pkg::coord_t len
);
  import dfst_pkg::*;

  logic [63:0] ua0, ub0, uc0, mx0;
  logic [63:0] ma, mb, mc, mxc;
  logic [5:0]  msb;
  logic [5:0]  kc;
  logic [63:0] ua1, ub1, uc1;
  logic [5:0]  k1, k2, k3;
  logic [30:0] sa, sb, sc;
  logic [61:0] qa, qb, qc;
  logic [63:0] n_q [SQRT_STAGES+1];
  logic [63:0] r_q [SQRT_STAGES+1];
  logic [5:0]  k_q [SQRT_STAGES+1];

  // magnitudes and their maximum
  always_comb begin
    ma  = a[63] ? 64'(-a) : 64'(a);
    mb  = b[63] ? 64'(-b) : 64'(b);
    mc  = c[63] ? 64'(-c) : 64'(c);
    mxc = (mb > ma) ? mb : ma;
    mxc = (mc > mxc) ? mc : mxc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua0 <= ma;
      ub0 <= mb;
      uc0 <= mc;
      mx0 <= mxc;
    end
  end

  // leading one of the maximum gives the normalizing shift
  always_comb begin
    msb = '0;
    for (int i = 0; i < 64; i++) begin
      if (mx0[i]) begin
        msb = 6'(i);
      end
    end
    kc = (msb > 6'd30) ? msb - 6'd30 : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua1 <= ua0;
      ub1 <= ub0;
      uc1 <= uc0;
      k1  <= kc;
    end
  end

  // shift into 31 bits
  always_ff @(posedge clk) begin
    if (en) begin
      sa <= 31'(ua1 >> k1);
      sb <= 31'(ub1 >> k1);
      sc <= 31'(uc1 >> k1);
      k2 <= k1;
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      qa <= sa * sa;
      qb <= sb * sb;
      qc <= sc * sc;
      k3 <= k2;
    end
  end

  // sum of squares seeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      n_q[0] <= 64'(qa) + 64'(qb) + 64'(qc);
      r_q[0] <= '0;
      k_q[0] <= k3;
    end
  end

  // integer root, two result bits per stage
  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sq
    localparam logic [63:0] B0 = 64'd1 << (62 - 4 * s);
    localparam logic [63:0] B1 = 64'd1 << (60 - 4 * s);
    logic [63:0] n1, r1, n2, r2;

    always_comb begin
      if (n_q[s] >= r_q[s] + B0) begin
        n1 = n_q[s] - (r_q[s] + B0);
        r1 = (r_q[s] >> 1) + B0;
      end else begin
        n1 = n_q[s];
        r1 = r_q[s] >> 1;
      end
      if (n1 >= r1 + B1) begin
        n2 = n1 - (r1 + B1);
        r2 = (r1 >> 1) + B1;
      end else begin
        n2 = n1;
        r2 = r1 >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[s+1] <= n2;
        r_q[s+1] <= r2;
        k_q[s+1] <= k_q[s];
      end
    end
  end

  // undo the normalization
  always_ff @(posedge clk) begin
    if (en) begin
      len <= coord_t'({32'b0, r_q[SQRT_STAGES][31:0]} << k_q[SQRT_STAGES]);
    end
  end

endmodule

// ===== rtl/dfst_muldiv.sv =====
// estimate update: floor(de * ls / lu) + 1.0, saturated, pipelined restoring divide
module dfst_muldiv (
  input  logic             clk,
  input  logic             en,
  input  logic [47:0]      de,
  input  dfst_pkg::coord_t ls,
  input  dfst_pkg::coord_t lu,
  output logic [47:0]      de_out
);
  import dfst_pkg::*;

  logic [63:0]  p00, p01;
  logic [47:0]  p10, p11;
  logic [63:0]  d1, d2, d3;
  logic [111:0] prod;
  logic [111:0] prod3;
  logic         sat3;
  logic [63:0]  rm_q [DIV_STAGES+1];
  logic [47:0]  lo_q [DIV_STAGES+1];
  logic [47:0]  qt_q [DIV_STAGES+1];
  logic [63:0]  dv_q [DIV_STAGES+1];
  logic         st_q [DIV_STAGES+1];

  // partial products, zero length replaced by one lsb
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= de[31:0] * ls[31:0];
      p01 <= de[31:0] * ls[63:32];
      p10 <= de[47:32] * ls[31:0];
      p11 <= de[47:32] * ls[63:32];
      d1  <= (lu == '0) ? 64'd1 : 64'(lu);
    end
  end

  // full product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 112'(p00) + (112'(p01) << 32) + (112'(p10) << 32) + (112'(p11) << 64);
      d2   <= d1;
    end
  end

  // quotient that does not fit in 48 bits saturates
  always_ff @(posedge clk) begin
    if (en) begin
      sat3  <= prod >= {d2, 48'b0};
      d3    <= d2;
      prod3 <= prod;
    end
  end

  always_comb begin
    rm_q[0] = prod3[111:48];
    lo_q[0] = prod3[47:0];
    qt_q[0] = '0;
    dv_q[0] = d3;
    st_q[0] = sat3;
  end

  // two quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_dv
    logic [64:0] t1, t2;
    logic [63:0] r1, r2;
    logic        b1, b2;

    always_comb begin
      t1 = {rm_q[s], lo_q[s][47]};
      b1 = t1 >= {1'b0, dv_q[s]};
      r1 = b1 ? 64'(t1 - {1'b0, dv_q[s]}) : t1[63:0];
      t2 = {r1, lo_q[s][46]};
      b2 = t2 >= {1'b0, dv_q[s]};
      r2 = b2 ? 64'(t2 - {1'b0, dv_q[s]}) : t2[63:0];
    end

    if (s == 0) begin : g_first
      logic [63:0] rm_s;
      logic [47:0] lo_s;
      logic [47:0] qt_s;
      logic [63:0] dv_s;
      logic        st_s;
      always_ff @(posedge clk) begin
        if (en) begin
          rm_s <= r2;
          lo_s <= {lo_q[s][45:0], 2'b0};
          qt_s <= {qt_q[s][45:0], b1, b2};
          dv_s <= dv_q[s];
          st_s <= st_q[s];
        end
      end
      assign rm_q[s+1] = rm_s;
      assign lo_q[s+1] = lo_s;
      assign qt_q[s+1] = qt_s;
      assign dv_q[s+1] = dv_s;
      assign st_q[s+1] = st_s;
    end else begin : g_rest
      logic [63:0] rm_s;
      logic [47:0] lo_s;
      logic [47:0] qt_s;
      logic [63:0] dv_s;
      logic        st_s;
      always_ff @(posedge clk) begin
        if (en) begin
          rm_s <= r2;
          lo_s <= {lo_q[s][45:0], 2'b0};
          qt_s <= {qt_q[s][45:0], b1, b2};
          dv_s <= dv_q[s];
          st_s <= st_q[s];
        end
      end
      assign rm_q[s+1] = rm_s;
      assign lo_q[s+1] = lo_s;
      assign qt_q[s+1] = qt_s;
      assign dv_q[s+1] = dv_s;
      assign st_q[s+1] = st_s;
    end
  end

  // add one and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      if (st_q[DIV_STAGES] || (qt_q[DIV_STAGES] > DE_MAX - ONE_DE)) begin
        de_out <= DE_MAX;
      end else begin
        de_out <= qt_q[DIV_STAGES] + ONE_DE;
      end
    end
  end

endmodule

// ===== rtl/diagonal_fold_scale_transform.sv =====
// Throughput: one request per cycle; the whole pipeline advances when the output
// register is empty or taken, so s_tready follows m_tready combinationally.
// The depth is set by the two chained length units and the 48-bit divide.
// Reset (rst, synchronous) empties the pipeline and restores the configuration registers.
module diagonal_fold_scale_transform #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // pos_x, pos_y, pos_z, pos_w, dist_est from bit 0 up
  input  logic [((4*COORD_WIDTH+48+7)/8)*8-1:0] s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // new_x, new_y, new_z, new_w, new_dist_est from bit 0 up
  output logic [((4*COORD_WIDTH+48+7)/8)*8-1:0] m_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  dfst_pkg::reg_index_t    cfg_index,
  input  logic [59:0]             cfg_data
);
  import dfst_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int DATA_W = ((4*COORD_WIDTH+48+7)/8)*8;
  localparam int EXT    = 64 - COORD_WIDTH;
  localparam int T_P    = 3 * MUL_LAT + LEN_LAT + 3;
  localparam int T_L    = T_P + LEN_LAT;
  localparam int T_OUT  = T_L + MD_LAT;
  localparam int T_I    = T_P + 3 * MUL_LAT + 5;
  localparam coord_t OMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam coord_t OMIN = -OMAX - 64'sd1;

  function automatic logic [COORD_WIDTH-1:0] sat_out(input coord_t v);
    coord_t s;
    s = (v > OMAX) ? OMAX : ((v < OMIN) ? OMIN : v);
    return s[COORD_WIDTH-1:0];
  endfunction

  logic              en;
  logic [T_OUT-1:0]  vld;
  logic [59:0]       off_r;
  logic [59:0]       scl_r;
  logic              rot_en_r;
  logic [53:0]       row_r [3];

  coord_t x_in, y_in, z_in;
  coord_t mx23, mz13, mx13, mz23, y_d;
  coord_t tmy, tpy, cc, a_v, b_v, c_d;
  coord_t h [3];
  coord_t dd [3];
  coord_t ps [3];
  coord_t p [3];
  coord_t d_al [3];
  coord_t p_al [3];
  coord_t rm [3][3];
  coord_t acc [3];
  coord_t r [3];
  coord_t lu, ls;
  logic [47:0] de_d, de_out;
  coord_t sv, dl, r2h, ts, yv, q13, q23, t23, t13, yv_d, q13_d, q23_d;
  coord_t xs, ys, zs;
  logic [CW-1:0] xo, yo, zo, w_d;
  logic [3*CW-1:0] xyz_d;

  // pipeline advance and valid bits
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[T_OUT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_OUT-2:0], s_tvalid};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      off_r    <= OFFSET_RST;
      scl_r    <= SCALE_RST;
      rot_en_r <= 1'b0;
      row_r[0] <= ROW0_RST;
      row_r[1] <= ROW1_RST;
      row_r[2] <= ROW2_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET: off_r    <= cfg_data;
        REG_SCALE:  scl_r    <= cfg_data;
        REG_ROT_EN: rot_en_r <= cfg_data[0];
        REG_ROW0:   row_r[0] <= cfg_data[53:0];
        REG_ROW1:   row_r[1] <= cfg_data[53:0];
        REG_ROW2:   row_r[2] <= cfg_data[53:0];
        default: ;
      endcase
    end
  end

  // input unpack
  assign x_in = {{EXT{s_tdata[CW-1]}}, s_tdata[CW-1:0]};
  assign y_in = {{EXT{s_tdata[2*CW-1]}}, s_tdata[2*CW-1:CW]};
  assign z_in = {{EXT{s_tdata[3*CW-1]}}, s_tdata[3*CW-1:2*CW]};

  // forward basis rotation
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_mx23 (.clk, .en, .v(x_in), .c(K_S23), .r(mx23));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_mz13 (.clk, .en, .v(z_in), .c(K_S13), .r(mz13));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_mx13 (.clk, .en, .v(x_in), .c(K_S13), .r(mx13));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_mz23 (.clk, .en, .v(z_in), .c(K_S23), .r(mz23));
  dfst_pipe #(.W(64), .DEPTH(MUL_LAT)) u_yd (.clk, .en, .d(y_in), .q(y_d));

  always_ff @(posedge clk) begin
    if (en) begin
      tmy <= mx23 - mz13 - y_d;
      tpy <= mx23 - mz13 + y_d;
      cc  <= mx13 + mz23;
    end
  end

  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_ma (.clk, .en, .v(tmy), .c(K_S12), .r(a_v));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_mb (.clk, .en, .v(tpy), .c(K_S12), .r(b_v));
  dfst_pipe #(.W(64), .DEPTH(MUL_LAT)) u_cd (.clk, .en, .d(cc), .q(c_d));

  // each axis becomes the length of the other two
  dfst_len3 u_h0 (.clk, .en, .a(b_v), .b(c_d), .c('0), .len(h[0]));
  dfst_len3 u_h1 (.clk, .en, .a(a_v), .b(c_d), .c('0), .len(h[1]));
  dfst_len3 u_h2 (.clk, .en, .a(a_v), .b(b_v), .c('0), .len(h[2]));

  // offset, fold and scale per axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    coord_t ofs, dv;
    assign ofs = {{40{off_r[20*i+19]}}, off_r[20*i +: 20], 4'b0};
    assign dv  = h[i] - ofs;

    always_ff @(posedge clk) begin
      if (en) begin
        dd[i] <= dv[63] ? -dv : dv;
      end
    end

    dfst_mulr #(.CW(20), .SHIFT(SC_SHIFT)) u_sc (
      .clk, .en, .v(dd[i]), .c(signed'(scl_r[20*i +: 20])), .r(ps[i])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        p[i] <= clamp_inner(ps[i]);
      end
    end

    dfst_pipe #(.W(64), .DEPTH(MUL_LAT+1)) u_dal (.clk, .en, .d(dd[i]), .q(d_al[i]));
    dfst_pipe #(.W(64), .DEPTH(MUL_LAT+1)) u_pal (.clk, .en, .d(p[i]), .q(p_al[i]));
  end

  // unscaled and scaled lengths, estimate update
  dfst_len3 u_lu (.clk, .en, .a(d_al[0]), .b(d_al[1]), .c(d_al[2]), .len(lu));
  dfst_len3 u_ls (.clk, .en, .a(p[0]), .b(p[1]), .c(p[2]), .len(ls));
  dfst_pipe #(.W(48), .DEPTH(T_L)) u_ded (
    .clk, .en, .d(s_tdata[4*CW+47:4*CW]), .q(de_d)
  );
  dfst_muldiv u_md (.clk, .en, .de(de_d), .ls(ls), .lu(lu), .de_out(de_out));

  // optional matrix, each term rounded on its own
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      dfst_mulr #(.CW(18), .SHIFT(SC_SHIFT)) u_rm (
        .clk, .en, .v(p[j]), .c(signed'(row_r[i][18*j +: 18])), .r(rm[i][j])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i] <= rm[i][0] + rm[i][1] + rm[i][2];
        r[i]   <= rot_en_r ? clamp_inner(acc[i]) : p_al[i];
      end
    end
  end

  // inverse basis rotation
  always_ff @(posedge clk) begin
    if (en) begin
      sv  <= r[1] + r[0];
      dl  <= r[1] - r[0];
      r2h <= r[2];
    end
  end

  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_ts  (.clk, .en, .v(sv), .c(K_S12), .r(ts));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_yv  (.clk, .en, .v(dl), .c(K_S12), .r(yv));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_q13 (.clk, .en, .v(r2h), .c(K_S13), .r(q13));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_q23 (.clk, .en, .v(r2h), .c(K_S23), .r(q23));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_t23 (.clk, .en, .v(ts), .c(K_S23), .r(t23));
  dfst_mulr #(.CW(25), .SHIFT(K_SHIFT)) u_t13 (.clk, .en, .v(ts), .c(K_S13), .r(t13));
  dfst_pipe #(.W(64), .DEPTH(MUL_LAT)) u_yvd  (.clk, .en, .d(yv), .q(yv_d));
  dfst_pipe #(.W(64), .DEPTH(MUL_LAT)) u_q13d (.clk, .en, .d(q13), .q(q13_d));
  dfst_pipe #(.W(64), .DEPTH(MUL_LAT)) u_q23d (.clk, .en, .d(q23), .q(q23_d));

  always_ff @(posedge clk) begin
    if (en) begin
      xs <= q13_d + t23;
      ys <= yv_d;
      zs <= q23_d - t13;
    end
  end

  // output saturation
  always_ff @(posedge clk) begin
    if (en) begin
      xo <= sat_out(xs);
      yo <= sat_out(ys);
      zo <= sat_out(zs);
    end
  end

  // align coordinates and w with the estimate
  dfst_pipe #(.W(3*CW), .DEPTH(T_OUT-T_I)) u_xyzd (
    .clk, .en, .d({zo, yo, xo}), .q(xyz_d)
  );
  dfst_pipe #(.W(CW), .DEPTH(T_OUT)) u_wd (
    .clk, .en, .d(s_tdata[4*CW-1:3*CW]), .q(w_d)
  );

  assign m_tdata = DATA_W'({de_out, w_d, xyz_d});

endmodule

// ===== rtl/dfst_checker.sv =====
// port level checks of the transform, bound to the top level
module dfst_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic [((4*COORD_WIDTH+48+7)/8)*8-1:0] s_tdata,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [((4*COORD_WIDTH+48+7)/8)*8-1:0] m_tdata,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input dfst_pkg::reg_index_t    cfg_index,
  input logic [59:0]             cfg_data
);
  import dfst_pkg::*;

  // pipeline empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input side advances exactly with the output register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // estimate always includes the added one
  a_de_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4*COORD_WIDTH+47:4*COORD_WIDTH] >= ONE_DE)
    else $error("estimate below one");

endmodule

bind diagonal_fold_scale_transform dfst_checker #(.COORD_WIDTH(COORD_WIDTH)) u_dfst_checker (.*);

// ===== dv/tb_diagonal_fold_scale_transform.sv =====
// self-checking testbench for diagonal_fold_scale_transform
module tb_diagonal_fold_scale_transform;
  import dfst_pkg::*;

  localparam int CW = 32;
  localparam int DW = ((4*CW+48+7)/8)*8;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [47:0]          de;
    logic signed [CW-1:0] w, z, y, x;
  } point_t;

  typedef struct {
    point_t pt;
    bit     typed;
    point_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_index_t cfg_index = REG_OFFSET;
  logic [59:0] cfg_data = '0;

  // shadow copy of the configuration
  logic [59:0] sh_offset = OFFSET_RST;
  logic [59:0] sh_scale = SCALE_RST;
  logic        sh_rot_en = 1'b0;
  logic [53:0] sh_row [3] = '{ROW0_RST, ROW1_RST, ROW2_RST};

  point_t pending_results [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int idle_cnt = 0;
  int burst_left = 1;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_cnt = 0;

  diagonal_fold_scale_transform #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // rounded product v*c/2^s, ties away from zero
  function automatic longint round_mul(input longint v, input longint c, input int s);
    logic [127:0] m, cm, r;
    longint sr;
    m = (v < 0) ? 128'(-v) : 128'(v);
    cm = (c < 0) ? 128'(-c) : 128'(c);
    r = (m * cm + (128'd1 << (s - 1))) >> s;
    if (r > (128'd1 << 62)) r = 128'd1 << 62;
    sr = longint'(r[63:0]);
    return ((v < 0) != (c < 0)) ? -sr : sr;
  endfunction

  function automatic longint clip_inner(input longint v);
    if (v > INNER_LIM) return INNER_LIM;
    if (v < -INNER_LIM) return -INNER_LIM;
    return v;
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] n);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // euclidean length with pre-shift to keep the squares in range
  function automatic longint vec_len(input longint a, input longint b, input longint c);
    logic [63:0] ua, ub, uc, mx;
    int k;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    uc = (c < 0) ? -c : c;
    mx = ua;
    k = 0;
    if (ub > mx) mx = ub;
    if (uc > mx) mx = uc;
    while ((mx >> k) >= (64'd1 << 31)) k++;
    ua = ua >> k;
    ub = ub >> k;
    uc = uc >> k;
    return longint'(int_root(ua * ua + ub * ub + uc * uc) << k);
  endfunction

  function automatic logic [47:0] next_estimate(input logic [47:0] de, input longint ls,
                                                input longint lu);
    logic [127:0] prod, q;
    prod = 128'(de) * 128'(ls);
    if ((prod >> 64) >= 128'(lu)) return DE_MAX;
    q = prod / 128'(lu);
    if (q > 128'(DE_MAX - ONE_DE)) return DE_MAX;
    return q[47:0] + ONE_DE;
  endfunction

  function automatic longint sat_coord(input longint v);
    longint mx;
    mx = (longint'(1) <<< (CW - 1)) - 1;
    if (v > mx) return mx;
    if (v < -mx - 1) return -mx - 1;
    return v;
  endfunction

  // expected transform of one point under the shadow configuration
  function automatic point_t fold_scale(input point_t pt);
    longint x, y, z, t, a, b, c, o, s, v, acc, lu, ls;
    longint h [3];
    longint d [3];
    longint p [3];
    longint r [3];
    logic signed [19:0] f20;
    logic signed [17:0] f18;
    point_t res;
    x = longint'(pt.x);
    y = longint'(pt.y);
    z = longint'(pt.z);
    t = round_mul(x, K_S23, K_SHIFT) - round_mul(z, K_S13, K_SHIFT);
    a = round_mul(t - y, K_S12, K_SHIFT);
    b = round_mul(t + y, K_S12, K_SHIFT);
    c = round_mul(x, K_S13, K_SHIFT) + round_mul(z, K_S23, K_SHIFT);
    h[0] = vec_len(b, c, 0);
    h[1] = vec_len(a, c, 0);
    h[2] = vec_len(a, b, 0);
    for (int i = 0; i < 3; i++) begin
      f20 = sh_offset[20*i +: 20];
      o = longint'(f20) * 16;
      f20 = sh_scale[20*i +: 20];
      s = longint'(f20);
      v = h[i] - o;
      d[i] = (v < 0) ? -v : v;
      p[i] = clip_inner(round_mul(d[i], s, SC_SHIFT));
    end
    lu = vec_len(d[0], d[1], d[2]);
    if (lu == 0) lu = 1;
    ls = vec_len(p[0], p[1], p[2]);
    res.de = next_estimate(pt.de, ls, lu);
    for (int i = 0; i < 3; i++) begin
      if (sh_rot_en) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          f18 = sh_row[i][18*j +: 18];
          acc += round_mul(p[j], longint'(f18), SC_SHIFT);
        end
        r[i] = clip_inner(acc);
      end else begin
        r[i] = p[i];
      end
    end
    t = round_mul(r[1] + r[0], K_S12, K_SHIFT);
    x = round_mul(r[2], K_S13, K_SHIFT) + round_mul(t, K_S23, K_SHIFT);
    y = round_mul(r[1] - r[0], K_S12, K_SHIFT);
    z = round_mul(r[2], K_S23, K_SHIFT) - round_mul(t, K_S13, K_SHIFT);
    res.x = CW'(sat_coord(x));
    res.y = CW'(sat_coord(y));
    res.z = CW'(sat_coord(z));
    res.w = pt.w;
    return res;
  endfunction

  // receiver: rotating stall patterns plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go) begin
      hold_go <= 1'b0;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt % 128 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[4*CW+47:0];
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: new_x expected %0d actual %0d", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: new_y expected %0d actual %0d", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: new_z expected %0d actual %0d", $time, want.z, got.z);
          errors++;
        end
        if (got.w !== want.w) begin
          $display("%0t: new_w expected %0d actual %0d", $time, want.w, got.w);
          errors++;
        end
        if (got.de !== want.de) begin
          $display("%0t: new_dist_est expected %0d actual %0d", $time, want.de, got.de);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_point(input point_t pt, input bit typed, input point_t res);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= DW'(pt);
    do @(posedge clk); while (!s_tready);
    n_items++;
    pending_results.push_back(typed ? res : fold_scale(pt));
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [59:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_OFFSET: sh_offset = val;
      REG_SCALE:  sh_scale = val;
      REG_ROT_EN: sh_rot_en = val[0];
      REG_ROW0:   sh_row[0] = val[53:0];
      REG_ROW1:   sh_row[1] = val[53:0];
      REG_ROW2:   sh_row[2] = val[53:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return {1'b0, {(CW-1){1'b1}}};
        1: return {1'b1, {(CW-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    end
    if (sel < 5) return $urandom;
    return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
  endfunction

  function automatic point_t rand_point();
    point_t pt;
    int sel;
    pt.x = rand_coord();
    pt.y = rand_coord();
    pt.z = rand_coord();
    pt.w = $urandom;
    sel = $urandom_range(0, 9);
    if (sel == 0) pt.de = '0;
    else if (sel == 1) pt.de = DE_MAX;
    else if (sel < 6) pt.de = 48'({$urandom, $urandom});
    else pt.de = 48'($urandom_range(0, 1 << 22));
    return pt;
  endfunction

  // three signed lanes of the given width packed from lane 0 up
  function automatic logic [59:0] rand_lanes(input int lw, input int span);
    logic [59:0] v;
    int f;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      f = $signed($urandom_range(0, 2 * span)) - span;
      v[lw*i +: 20] = 20'(f);
    end
    return v & ((60'd1 << (3 * lw)) - 1);
  endfunction

  task automatic run_random(input int n, input bit with_pressure);
    point_t dummy;
    dummy = '0;
    for (int i = 0; i < n; i++) begin
      if (with_pressure && i == n / 3) hold_go = 1'b1;
      if (with_pressure && i == (2 * n) / 3) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      send_point(rand_point(), 1'b0, dummy);
    end
  endtask

  task automatic run_table(input dir_row_t rows []);
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].res);
  endtask

  initial begin
    dir_row_t base_rows [];
    dir_row_t zero_rows [];
    point_t zp, zr;
    logic signed [CW-1:0] cmax, cmin;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    zp = '0;
    zr = '0;
    zr.de = ONE_DE;

    // directed points under the reset configuration
    base_rows = new[10];
    base_rows[0] = '{'{48'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 0, zp};
    base_rows[1] = '{'{DE_MAX, cmax, cmax, cmax, cmax}, 0, zp};
    base_rows[2] = '{'{DE_MAX, cmin, cmin, cmin, cmin}, 0, zp};
    base_rows[3] = '{'{48'd65536, 32'sd0, cmin, 32'sd0, cmax}, 0, zp};
    base_rows[4] = '{'{48'd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 0, zp};
    base_rows[5] = '{'{48'h5555_5555_5555, 32'sh5555_5555, 32'sh2AAA_AAAA,
                       32'shAAAA_AAAA, 32'sh5555_5555}, 0, zp};
    base_rows[6] = '{'{48'hAAAA_AAAA_AAAA, -32'sd1048576, 32'sd1048576,
                       32'sd0, 32'sd1048576}, 0, zp};
    base_rows[7] = '{'{48'd65536, 32'sd0, 32'sd0, 32'sd1048576, 32'sd0}, 0, zp};
    base_rows[8] = '{'{DE_MAX, 32'sd7, cmax, cmin, cmax}, 0, zp};
    base_rows[9] = '{'{48'd12345, 32'sd3, 32'sd0, 32'sd0, 32'sd0}, 0, zp};

    // zero offset: the origin has zero unscaled length, estimate becomes one
    zero_rows = new[3];
    zero_rows[0] = '{zp, 1, zr};
    zp.de = DE_MAX;
    zp.w = cmin;
    zr.w = cmin;
    zero_rows[1] = '{zp, 1, zr};
    zp.w = cmax;
    zr.w = cmax;
    zero_rows[2] = '{zp, 1, zr};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_table(base_rows);
    run_random(300, 1'b0);
    wait_drained();

    write_reg(REG_OFFSET, rand_lanes(20, 1 << 18));
    write_reg(REG_SCALE, rand_lanes(20, 1 << 18));
    run_random(250, 1'b0);
    wait_drained();

    // offset at its positive extreme, scale at its negative extreme
    write_reg(REG_OFFSET, {3{20'h7FFFF}});
    write_reg(REG_SCALE, {3{20'h80000}});
    run_random(200, 1'b0);
    wait_drained();

    write_reg(REG_OFFSET, {3{20'h80000}});
    write_reg(REG_SCALE, {3{20'h7FFFF}});
    run_random(200, 1'b0);
    wait_drained();

    // configured rotation with random coefficients, long stall and a pause
    write_reg(REG_ROT_EN, 60'd1);
    write_reg(REG_ROW0, rand_lanes(18, 1 << 17));
    write_reg(REG_ROW1, rand_lanes(18, 1 << 17));
    write_reg(REG_ROW2, rand_lanes(18, 1 << 17));
    write_reg(REG_OFFSET, rand_lanes(20, 1 << 18));
    write_reg(REG_SCALE, rand_lanes(20, 1 << 17));
    run_random(300, 1'b1);
    wait_drained();

    // coefficient extremes
    write_reg(REG_ROW0, {18'h1FFFF, 18'h20000, 18'h1FFFF});
    write_reg(REG_ROW1, {3{18'h20000}});
    write_reg(REG_ROW2, {3{18'h1FFFF}});
    write_reg(REG_SCALE, {3{20'h7FFFF}});
    run_random(200, 1'b0);
    wait_drained();

    // writes to unused indexes must leave the registers alone
    write_reg(reg_index_t'(6), 60'({$urandom, $urandom}));
    write_reg(reg_index_t'(7), 60'({$urandom, $urandom}));
    write_reg(REG_ROT_EN, 60'd0);
    write_reg(REG_SCALE, SCALE_RST);
    write_reg(REG_OFFSET, '0);
    run_table(zero_rows);
    run_random(250, 1'b0);
    wait_drained();

    $display("covered %0d points, %0d results and %0d register writes", n_items,
             n_results, n_cfg);
    $display("configs: reset, random, offset/scale extremes, rotation, zero offset");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== diagonal_fold_scale_transform.f =====
rtl/dfst_pkg.sv
rtl/dfst_pipe.sv
rtl/dfst_mulr.sv
rtl/dfst_len3.sv
rtl/dfst_muldiv.sv
rtl/diagonal_fold_scale_transform.sv
rtl/dfst_checker.sv
dv/tb_diagonal_fold_scale_transform.sv
